@@ rtl/evad_pkg.sv @@
// evad_pkg: widths, codes, shared types and helpers of the energy voice activity detector
// no dependencies; compiled first

package evad_pkg;

    // fixed sizes of the design
    localparam int MAX_FRAME   = 4096;
    localparam int SAMPLE_BITS = 16;

    // register field widths
    localparam int THR_W   = 31;
    localparam int ONSET_W = 8;
    localparam int MS_W    = 16;
    localparam int HANG_W  = 8;
    localparam int RATE_W  = 18;

    // state widths
    localparam int CNT_W    = 16;
    localparam int LEN_W    = $clog2(MAX_FRAME) + 1;
    localparam int SQ_W     = 2 * SAMPLE_BITS - 1;
    localparam int ENERGY_W = SQ_W + LEN_W - 1;

    // milliseconds to seconds scale for the duration tests
    localparam int MS_SCALE   = 1000;
    localparam int MS_SCALE_W = 10;

    // shared multiplier sizes
    localparam int CL_W   = CNT_W + LEN_W;
    localparam int HAVE_W = CL_W + MS_SCALE_W;
    localparam int NEED_W = MS_W + RATE_W;
    localparam int TL_W   = THR_W + LEN_W;
    localparam int MUL_A_W_0 = (THR_W > CL_W) ? THR_W : CL_W;
    localparam int MUL_A_W   = (MUL_A_W_0 > SAMPLE_BITS) ? MUL_A_W_0 : SAMPLE_BITS;
    localparam int MUL_B_W_0 = (RATE_W > LEN_W) ? RATE_W : LEN_W;
    localparam int MUL_B_W_1 = (MUL_B_W_0 > MS_SCALE_W) ? MUL_B_W_0 : MS_SCALE_W;
    localparam int MUL_B_W   = (MUL_B_W_1 > SAMPLE_BITS) ? MUL_B_W_1 : SAMPLE_BITS;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int PROD_W_0  = (TL_W > HAVE_W) ? TL_W : HAVE_W;
    localparam int PROD_W    = (PROD_W_0 > SQ_W) ? PROD_W_0 : SQ_W;
    localparam int VC_W      = (ENERGY_W > PROD_W) ? ENERGY_W : PROD_W;
    localparam int DC_W      = (HAVE_W > NEED_W) ? HAVE_W : NEED_W;

    // configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_THRESHOLD   = 3'd0,
        REG_ONSET       = 3'd1,
        REG_MIN_SPEECH  = 3'd2,
        REG_HANGOVER    = 3'd3,
        REG_MIN_SILENCE = 3'd4,
        REG_RATE        = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_START = 2'd1,
        EV_END   = 2'd2
    } t_event;

    typedef struct packed {
        logic [THR_W-1:0]   threshold_squared;
        logic [ONSET_W-1:0] onset_needed;
        logic [MS_W-1:0]    min_speech_time;
        logic [HANG_W-1:0]  hangover_length;
        logic [MS_W-1:0]    min_silence_time;
        logic [RATE_W-1:0]  rate_hz;
    } t_cfg;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic sqr;
        logic acc;
        logic mul_thr;
        logic mul_cnt;
        logic mul_have;
        logic mul_need;
        logic decide;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic last;
        logic out_free;
    } t_dp_sts;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

endpackage

@@ rtl/evad_if.sv @@
// evad_smp_if / evad_res_if: valid-ready channels for samples and frame results
// depends on evad_pkg

interface evad_smp_if import evad_pkg::*;;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          frame_end;

    modport source (output valid, output sample, output frame_end, input ready);
    modport sink   (input valid, input sample, input frame_end, output ready);
endinterface

interface evad_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_res;
    logic       in_speech;

    modport source (output valid, output event_res, output in_speech, input ready);
    modport sink   (input valid, input event_res, input in_speech, output ready);
endinterface

@@ rtl/evad_regs.sv @@
// evad_regs: apb configuration registers of the detector
// depends on evad_pkg

module evad_regs import evad_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                REG_THRESHOLD:   n_cfg.threshold_squared = pwdata[THR_W-1:0];
                REG_ONSET:       n_cfg.onset_needed      = pwdata[ONSET_W-1:0];
                REG_MIN_SPEECH:  n_cfg.min_speech_time   = pwdata[MS_W-1:0];
                REG_HANGOVER:    n_cfg.hangover_length   = pwdata[HANG_W-1:0];
                REG_MIN_SILENCE: n_cfg.min_silence_time  = pwdata[MS_W-1:0];
                REG_RATE:        n_cfg.rate_hz           = pwdata[RATE_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_THRESHOLD:   prdata = DATA_W'(r_cfg.threshold_squared);
            REG_ONSET:       prdata = DATA_W'(r_cfg.onset_needed);
            REG_MIN_SPEECH:  prdata = DATA_W'(r_cfg.min_speech_time);
            REG_HANGOVER:    prdata = DATA_W'(r_cfg.hangover_length);
            REG_MIN_SILENCE: prdata = DATA_W'(r_cfg.min_silence_time);
            REG_RATE:        prdata = DATA_W'(r_cfg.rate_hz);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold_squared <= THR_W'(107374);
            r_cfg.onset_needed      <= ONSET_W'(2);
            r_cfg.min_speech_time   <= MS_W'(250);
            r_cfg.hangover_length   <= HANG_W'(10);
            r_cfg.min_silence_time  <= MS_W'(500);
            r_cfg.rate_hz           <= RATE_W'(16000);
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

@@ rtl/evad_ctrl.sv @@
// evad_ctrl: sequencer for per-sample accumulation and the frame-end decision steps
// depends on evad_pkg

module evad_ctrl import evad_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_SQR  = 8'b0000_0010,
        ST_ACC  = 8'b0000_0100,
        ST_THR  = 8'b0000_1000,
        ST_CNT  = 8'b0001_0000,
        ST_HAVE = 8'b0010_0000,
        ST_NEED = 8'b0100_0000,
        ST_DEC  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SQR;
                end
            end
            ST_SQR: begin
                o_cmd.sqr = 1'b1;
                n_state   = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_sts.last ? ST_THR : ST_IDLE;
            end
            ST_THR: begin
                o_cmd.mul_thr = 1'b1;
                n_state       = ST_CNT;
            end
            ST_CNT: begin
                o_cmd.mul_cnt = 1'b1;
                n_state       = ST_HAVE;
            end
            ST_HAVE: begin
                o_cmd.mul_have = 1'b1;
                n_state        = ST_NEED;
            end
            ST_NEED: begin
                o_cmd.mul_need = 1'b1;
                n_state        = ST_DEC;
            end
            ST_DEC: begin
                if (i_sts.out_free) begin
                    o_cmd.decide = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/evad_dp.sv @@
// evad_dp: energy accumulator, shared multiplier, onset/hangover state and result register
// depends on evad_pkg

module evad_dp import evad_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    output t_dp_sts                       o_sts,
    input  t_cfg                          i_cfg,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_frame_end,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output logic [1:0]                    o_event_res,
    output logic                          o_in_speech
);

    // payload registers
    logic [SAMPLE_BITS-1:0] r_mag;
    logic                   r_fe;
    logic [PROD_W-1:0]      r_prod;
    logic [NEED_W-1:0]      r_need;
    logic                   r_voice;
    t_event                 r_event;
    logic                   r_speech;

    // detector state
    logic                   r_active;
    logic [CNT_W-1:0]       r_onset;
    logic [CNT_W-1:0]       r_speech_cnt;
    logic [CNT_W-1:0]       r_silence;
    logic [HANG_W-1:0]      r_hang;
    logic [ENERGY_W-1:0]    r_energy;
    logic [LEN_W-1:0]       r_len;
    logic                   r_out_valid;

    logic                   n_active;
    logic [CNT_W-1:0]       n_onset;
    logic [CNT_W-1:0]       n_speech_cnt;
    logic [CNT_W-1:0]       n_silence;
    logic [HANG_W-1:0]      n_hang;
    t_event                 n_event;

    logic [SAMPLE_BITS-1:0] mag;
    logic [LEN_W-1:0]       len_inc;
    logic [CNT_W-1:0]       onset_inc;
    logic [CNT_W-1:0]       speech_inc;
    logic [CNT_W-1:0]       silence_inc;
    logic [CNT_W-1:0]       cnt_sel;
    logic [MS_W-1:0]        ms_sel;
    logic                   long_ok;
    logic [MUL_A_W-1:0]     mul_a;
    logic [MUL_B_W-1:0]     mul_b;
    logic [MUL_P_W-1:0]     mul_full;

    // magnitude; the most negative code wraps onto its own magnitude
    assign mag = i_sample[SAMPLE_BITS-1] ? (~i_sample + 1'b1) : i_sample;

    assign len_inc     = r_len + 1'b1;
    assign onset_inc   = sat_inc(r_onset);
    assign speech_inc  = sat_inc(r_speech_cnt);
    assign silence_inc = sat_inc(r_silence);
    assign cnt_sel     = r_active ? silence_inc : speech_inc;
    assign ms_sel      = r_active ? i_cfg.min_silence_time : i_cfg.min_speech_time;
    assign long_ok     = DC_W'(r_prod[HAVE_W-1:0]) >= DC_W'(r_need);

    assign o_sts.last     = r_fe || (len_inc == LEN_W'(MAX_FRAME));
    assign o_sts.out_free = !r_out_valid || i_res_ready;

    assign o_res_valid = r_out_valid;
    assign o_event_res = r_event;
    assign o_in_speech = r_speech;

    // shared multiplier operand selection
    always_comb begin
        mul_a = MUL_A_W'(r_mag);
        mul_b = MUL_B_W'(r_mag);
        if (i_cmd.mul_thr) begin
            mul_a = MUL_A_W'(i_cfg.threshold_squared);
            mul_b = MUL_B_W'(r_len);
        end else if (i_cmd.mul_cnt) begin
            mul_a = MUL_A_W'(cnt_sel);
            mul_b = MUL_B_W'(r_len);
        end else if (i_cmd.mul_have) begin
            mul_a = MUL_A_W'(r_prod[CL_W-1:0]);
            mul_b = MUL_B_W'(MS_SCALE);
        end else if (i_cmd.mul_need) begin
            mul_a = MUL_A_W'(ms_sel);
            mul_b = MUL_B_W'(i_cfg.rate_hz);
        end
    end

    assign mul_full = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

    // onset / hangover update at frame end
    always_comb begin
        n_active     = r_active;
        n_onset      = r_onset;
        n_speech_cnt = r_speech_cnt;
        n_silence    = r_silence;
        n_hang       = r_hang;
        n_event      = EV_NONE;
        if (!r_active) begin
            if (r_voice) begin
                n_onset      = onset_inc;
                n_speech_cnt = speech_inc;
                if ((onset_inc >= CNT_W'(i_cfg.onset_needed)) && long_ok) begin
                    n_active = 1'b1;
                    n_hang   = i_cfg.hangover_length;
                    n_event  = EV_START;
                end
            end else begin
                n_onset      = '0;
                n_speech_cnt = '0;
                n_silence    = '0;
            end
        end else if (r_voice) begin
            n_hang       = i_cfg.hangover_length;
            n_silence    = '0;
            n_speech_cnt = speech_inc;
        end else if (r_hang != '0) begin
            n_hang = r_hang - 1'b1;
        end else begin
            n_silence = silence_inc;
            if (long_ok) begin
                n_active     = 1'b0;
                n_onset      = '0;
                n_speech_cnt = '0;
                n_silence    = '0;
                n_event      = EV_END;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_onset      <= '0;
            r_speech_cnt <= '0;
            r_silence    <= '0;
            r_hang       <= '0;
            r_energy     <= '0;
            r_len        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.acc) begin
                r_energy <= r_energy + ENERGY_W'(r_prod[SQ_W-1:0]);
                r_len    <= len_inc;
            end
            if (i_cmd.decide) begin
                r_active     <= n_active;
                r_onset      <= n_onset;
                r_speech_cnt <= n_speech_cnt;
                r_silence    <= n_silence;
                r_hang       <= n_hang;
                r_energy     <= '0;
                r_len        <= '0;
                r_out_valid  <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag <= mag;
            r_fe  <= i_frame_end;
        end
        if (i_cmd.sqr || i_cmd.mul_thr || i_cmd.mul_cnt || i_cmd.mul_have) begin
            r_prod <= mul_full[PROD_W-1:0];
        end
        if (i_cmd.mul_cnt) begin
            // r_prod still holds threshold * length here
            r_voice <= VC_W'(r_energy) > VC_W'(r_prod);
        end
        if (i_cmd.mul_need) begin
            r_need <= mul_full[NEED_W-1:0];
        end
        if (i_cmd.decide) begin
            r_event  <= n_event;
            r_speech <= n_active;
        end
    end

endmodule

@@ rtl/energy_voice_activity_detector.sv @@
// energy_voice_activity_detector: top level of the energy detector with onset and hangover
// depends on evad_pkg, evad_if, evad_regs, evad_ctrl, evad_dp
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+---------------------------------------
//  i_smp    | in  | valid / ready        | sample (16 b signed), frame_end (1 b)
//  o_res    | out | valid / ready        | event_res (2 b), in_speech (1 b)
//  apb      | in  | psel/penable/pwrite  | paddr (5 b), pwdata/prdata (32 b)
//
// a sample transaction goes through accept, square on the shared multiplier and
// accumulate; the sequencer keeps ready low until the accumulate step is done
// a frame-end sample then takes 4 more multiplies on the same unit (threshold,
// count x length, x1000, ms x rate) and the decision step; that step waits while
// an earlier result still sits unread in the output register
// the output register parts the two sides: new samples are taken while a result waits
// reset (synchronous, active low) clears the state and the counters and restores the
// register defaults; no clearing pass is needed

module energy_voice_activity_detector import evad_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    evad_smp_if.sink          i_smp,
    evad_res_if.source        o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg    cfg;
    t_dp_cmd cmd;
    t_dp_sts sts;

    // configuration registers, to be written only between frames; the block does not enforce this
    evad_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer: owns the input ready and steps the shared multiplier
    evad_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_smp.valid),
        .o_in_ready (i_smp.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath: energy sum, frame length, decision state and output register
    evad_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg       (cfg),
        .i_sample    (i_smp.sample),
        .i_frame_end (i_smp.frame_end),
        .o_res_valid (o_res.valid),
        .i_res_ready (o_res.ready),
        .o_event_res (o_res.event_res),
        .o_in_speech (o_res.in_speech)
    );

endmodule

@@ bench/tb_top.sv @@
// tb_top: self-checking bench for energy_voice_activity_detector, driving samples, results and
// register writes; a mirrored onset/hangover tracker predicts every frame verdict
// depends on evad_pkg, evad_smp_if, evad_res_if and the detector rtl
`timescale 1ns / 1ps

module tb_top;
    import evad_pkg::*;

    // cycles to let a sample still in the datapath finish before a register write
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 10_000_000;

    localparam t_cfg CFG_AT_RESET = '{
        threshold_squared: 107374,
        onset_needed:      2,
        min_speech_time:   250,
        hangover_length:   10,
        min_silence_time:  500,
        rate_hz:           16000
    };

    // one frame verdict as the detector should report it
    typedef struct packed {
        t_event ev;
        logic   in_speech;
    } t_verdict;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    evad_smp_if smp_ch ();
    evad_res_if res_ch ();

    energy_voice_activity_detector dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // register mirror and tracker state, reset values as the block comes out of reset
    t_cfg        vad_cfg       = CFG_AT_RESET;
    logic        vad_active    = 1'b0;
    logic [15:0] onset_cnt     = '0;
    logic [15:0] speech_cnt    = '0;
    logic [15:0] silence_cnt   = '0;
    logic [7:0]  hang_cnt      = '0;
    logic [63:0] frame_energy  = '0;
    int unsigned frame_samples = 0;

    t_verdict    verdicts_due[$];
    t_verdict    head;
    int unsigned samples_sent   = 0;
    int unsigned fail_count     = 0;
    int unsigned cycle_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    bit          scramble_upper = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver back-pressure, redrawn every cycle
    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // result checker: every result transaction against the oldest verdict waiting
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (verdicts_due.size() == 0) begin
                $display("%0t: result with none expected: event_res %0d in_speech %0b",
                         $time, res_ch.event_res, res_ch.in_speech);
                fail_count++;
            end else begin
                head = verdicts_due.pop_front();
                if (res_ch.event_res !== head.ev) begin
                    $display("%0t: event_res expected %0d actual %0d",
                             $time, head.ev, res_ch.event_res);
                    fail_count++;
                end
                if (res_ch.in_speech !== head.in_speech) begin
                    $display("%0t: in_speech expected %0b actual %0b",
                             $time, head.in_speech, res_ch.in_speech);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic [15:0] count_up(input logic [15:0] c);
        return (&c) ? c : c + 16'd1;
    endfunction

    // duration test without division: frames*len/rate >= ms/1000
    function automatic bit duration_met(input logic [15:0] frames, input int unsigned len,
                                        input logic [15:0] ms);
        logic [63:0] have;
        logic [63:0] need;
        have = 64'(frames) * 64'(len) * 64'd1000;
        need = 64'(ms) * 64'(vad_cfg.rate_hz);
        return have >= need;
    endfunction

    // square-and-add per sample; on a frame end, voice decision and the onset/hangover fsm
    task automatic track_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic fe);
        logic signed [31:0] wide;
        int unsigned        len;
        bit                 voice;
        t_event             ev;
        wide = s;
        frame_energy += 64'(wide * wide);
        frame_samples++;
        if (!fe && frame_samples < MAX_FRAME)
            return;
        len   = frame_samples;
        voice = frame_energy > 64'(vad_cfg.threshold_squared) * 64'(len);
        frame_energy  = '0;
        frame_samples = 0;
        ev = EV_NONE;
        if (!vad_active) begin
            if (voice) begin
                onset_cnt  = count_up(onset_cnt);
                speech_cnt = count_up(speech_cnt);
                if (onset_cnt >= vad_cfg.onset_needed &&
                    duration_met(speech_cnt, len, vad_cfg.min_speech_time)) begin
                    vad_active = 1'b1;
                    hang_cnt   = vad_cfg.hangover_length;
                    ev         = EV_START;
                end
            end else begin
                onset_cnt   = '0;
                speech_cnt  = '0;
                silence_cnt = '0;
            end
        end else if (voice) begin
            hang_cnt    = vad_cfg.hangover_length;
            silence_cnt = '0;
            speech_cnt  = count_up(speech_cnt);
        end else if (hang_cnt != 0) begin
            hang_cnt--;
        end else begin
            silence_cnt = count_up(silence_cnt);
            if (duration_met(silence_cnt, len, vad_cfg.min_silence_time)) begin
                vad_active  = 1'b0;
                onset_cnt   = '0;
                speech_cnt  = '0;
                silence_cnt = '0;
                ev          = EV_END;
            end
        end
        verdicts_due.push_back('{ev: ev, in_speech: vad_active});
    endtask

    // called and returns at a falling edge; valid stays high into the next call
    task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic fe);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            smp_ch.valid <= 1'b0;
            @(negedge i_clk);
            while ($urandom_range(0, 99) < send_idle_pct) @(negedge i_clk);
        end
        smp_ch.valid     <= 1'b1;
        smp_ch.sample    <= s;
        smp_ch.frame_end <= fe;
        @(posedge i_clk);
        while (!smp_ch.ready) @(posedge i_clk);
        track_sample(s, fe);
        samples_sent++;
        @(negedge i_clk);
    endtask

    // hold the sender until every verdict is in and the datapath has gone quiet
    task automatic settle();
        smp_ch.valid <= 1'b0;
        while (verdicts_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // setup then access phase; psel is left high so writes can follow back to back
    task automatic write_reg(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] keep;
        logic [DATA_W-1:0] bus_word;
        keep = '1;
        case (idx)
            REG_THRESHOLD: begin
                keep = {DATA_W{1'b1}} >> (DATA_W - THR_W);
                vad_cfg.threshold_squared = value[THR_W-1:0];
            end
            REG_ONSET: begin
                keep = {DATA_W{1'b1}} >> (DATA_W - ONSET_W);
                vad_cfg.onset_needed = value[ONSET_W-1:0];
            end
            REG_MIN_SPEECH: begin
                keep = {DATA_W{1'b1}} >> (DATA_W - MS_W);
                vad_cfg.min_speech_time = value[MS_W-1:0];
            end
            REG_HANGOVER: begin
                keep = {DATA_W{1'b1}} >> (DATA_W - HANG_W);
                vad_cfg.hangover_length = value[HANG_W-1:0];
            end
            REG_MIN_SILENCE: begin
                keep = {DATA_W{1'b1}} >> (DATA_W - MS_W);
                vad_cfg.min_silence_time = value[MS_W-1:0];
            end
            REG_RATE: begin
                keep = {DATA_W{1'b1}} >> (DATA_W - RATE_W);
                vad_cfg.rate_hz = value[RATE_W-1:0];
            end
            default: ;
        endcase
        // junk above the field must be ignored by the block
        bus_word = scramble_upper ? (value | ($urandom() & ~keep)) : value;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= bus_word;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic load_config(input logic [DATA_W-1:0] thr, onset, speech_ms, hang,
                               silence_ms, rate);
        settle();
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_ONSET, onset);
        write_reg(REG_MIN_SPEECH, speech_ms);
        write_reg(REG_HANGOVER, hang);
        write_reg(REG_MIN_SILENCE, silence_ms);
        write_reg(REG_RATE, rate);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // reset defaults, single-sample frames at the sample extremes and one two-sample frame
    task automatic test_field_extremes();
        push_sample(16'sh7FFF, 1'b1);
        push_sample(-16'sh8000, 1'b1);
        push_sample(16'sh0000, 1'b1);
        push_sample(-16'sh0001, 1'b1);
        push_sample(16'sh0001, 1'b1);
        push_sample(16'sh7FFF, 1'b0);
        push_sample(-16'sh8000, 1'b1);
    endtask

    // one loud frame closed by its length alone, no frame_end anywhere
    task automatic test_overlong_frame();
        int v;
        for (int k = 1; k <= MAX_FRAME; k++) begin
            v = int'($urandom_range(20000, 32767));
            if ($urandom_range(0, 1) == 1)
                v = -v;
            push_sample(16'(v), 1'b0);
        end
    endtask

    // all registers at their top values, threshold and rate with upper bits set, then all at zero:
    // zero rate passes every duration test, zero onset and hangover act at once
    task automatic test_register_extremes();
        load_config('1, 32'd255, 32'd65535, 32'd255, 32'd65535, '1);
        push_sample(-16'sh8000, 1'b1);
        push_sample(16'sh7FFF, 1'b1);
        push_sample(16'sh0000, 1'b1);
        load_config('0, '0, '0, '0, '0, '0);
        repeat (9) push_sample(16'sh0000, 1'b1);
        push_sample(16'sh0005, 1'b1);
        push_sample(16'sh0000, 1'b1);
        push_sample(-16'sh0005, 1'b1);
        push_sample(-16'sh0005, 1'b1);
        push_sample(16'sh0000, 1'b1);
    endtask

    // a register change between samples of one frame counts at that frame's end
    task automatic test_midframe_write();
        load_config(32'd1_000_000, 32'd1, 32'd0, 32'd0, 32'd0, 32'd16000);
        repeat (3) push_sample(16'sh6000, 1'b0);
        load_config(32'h7FFF_FFFF, 32'd1, 32'd0, 32'd0, 32'd0, 32'd16000);
        push_sample(16'sh6000, 1'b1);
        repeat (3) push_sample(16'sh000A, 1'b0);
        load_config(32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd16000);
        push_sample(16'sh0000, 1'b1);
    endtask

    // alternating loud and quiet bursts of frames, some noise frames with stray frame ends,
    // fresh register settings every so often and the odd full drain
    task automatic run_random_phase(input int idle_pct, input int stall_pct, input int quota);
        int unsigned quota_end;
        int unsigned next_cfg;
        int          frames;
        int          len;
        int          amp;
        int          kind;
        int          v;
        int          k;
        bit          loud;
        logic [DATA_W-1:0] thr;
        logic [DATA_W-1:0] rate;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        quota_end = samples_sent + quota;
        next_cfg  = samples_sent;
        loud      = 1'b0;
        while (samples_sent < quota_end) begin
            if (samples_sent >= next_cfg) begin
                kind = $urandom_range(0, 19);
                thr  = (kind < 2) ? 32'd0 :
                       (kind == 2) ? 32'd1073741824 : $urandom_range(2_000_000, 120_000_000);
                kind = $urandom_range(0, 19);
                rate = (kind < 2) ? 32'd0 :
                       (kind == 2) ? 32'd192000 : $urandom_range(1, 2000);
                scramble_upper = $urandom_range(0, 1);
                load_config(thr,
                            ($urandom_range(0, 19) == 0) ? 32'd255 : $urandom_range(0, 5),
                            ($urandom_range(0, 19) == 0) ? 32'd65535 : $urandom_range(0, 10),
                            ($urandom_range(0, 19) == 0) ? 32'd255 : $urandom_range(0, 4),
                            ($urandom_range(0, 19) == 0) ? 32'd65535 : $urandom_range(0, 20),
                            rate);
                scramble_upper = 1'b0;
                next_cfg = samples_sent + $urandom_range(60, 160);
            end
            loud   = !loud;
            frames = loud ? $urandom_range(1, 8) : $urandom_range(1, 14);
            repeat (frames) begin
                kind = $urandom_range(0, 9);
                len  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
                amp  = loud ? $urandom_range(16000, 32767) : $urandom_range(0, 1500);
                for (k = 1; k <= len; k++) begin
                    if (kind == 0) begin
                        push_sample(16'($urandom()), ($urandom_range(0, 5) == 0) || k == len);
                    end else begin
                        v = int'($urandom_range(0, 2 * amp)) - amp;
                        push_sample(16'(v), k == len);
                    end
                end
                if ($urandom_range(0, 49) == 0)
                    settle();
            end
        end
    endtask

    initial begin
        smp_ch.valid     = 1'b0;
        smp_ch.sample    = '0;
        smp_ch.frame_end = 1'b0;
        res_ch.ready     = 1'b1;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_field_extremes();
        test_overlong_frame();
        test_register_extremes();
        test_midframe_write();
        run_random_phase(0, 0, 450);
        run_random_phase(58, 0, 450);
        run_random_phase(0, 58, 450);
        run_random_phase(32, 32, 450);

        settle();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
